>>> rtl/hlcd_pkg.sv
// Package with the frame geometry and pin-word constants of the handheld LCD timing generator.
package hlcd_pkg;

  localparam int unsigned WORDS_PER_LINE = 108;
  localparam int unsigned LEAD_WORDS     = 12;
  localparam int unsigned FRAME_LINES    = 154;
  localparam int unsigned VISIBLE_LINES  = 144;
  localparam int unsigned VISIBLE_PIXELS = 160;
  localparam int unsigned PIXEL_WORDS    = (VISIBLE_PIXELS / 4) * 2;

  localparam int unsigned WORD_W = 7;
  localparam int unsigned LINE_W = 8;

  localparam logic [WORD_W-1:0] LAST_WORD     = WORD_W'(WORDS_PER_LINE - 1);
  localparam logic [WORD_W-1:0] HSYNC_WORD    = WORD_W'(LEAD_WORDS - 1);
  localparam logic [WORD_W-1:0] FIRST_PIXEL   = WORD_W'(LEAD_WORDS);
  localparam logic [WORD_W-1:0] PIXEL_END     = WORD_W'(LEAD_WORDS + PIXEL_WORDS);
  localparam logic [WORD_W-1:0] CPG_WORD_A    = WORD_W'(50);
  localparam logic [WORD_W-1:0] CPG_WORD_B    = WORD_W'(70);
  localparam logic [LINE_W-1:0] VISIBLE_LAST  = LINE_W'(VISIBLE_LINES);
  localparam logic [LINE_W:0]   FRAME_END     = (LINE_W+1)'(FRAME_LINES);
  localparam logic [LINE_W:0]   BLANK_START   = (LINE_W+1)'(VISIBLE_LINES);

  localparam logic [31:0] VSYNC_BITS  = 32'h1010_1010;
  localparam logic [31:0] FR_BITS     = 32'h2020_2020;
  localparam logic [31:0] CP_BITS     = 32'h0004_0004;
  localparam logic [31:0] LAST_MARK   = 32'hC0C0_8080;
  localparam logic [31:0] FIRST_MARK  = 32'h0080_0000;
  localparam logic [31:0] SECOND_MARK = 32'h8080_0000;
  localparam logic [31:0] CPG_BITS    = 32'h8080_0000;
  localparam logic [31:0] HSYNC_MARK  = 32'h0000_0800;
  localparam logic [31:0] HSYNC_TAIL  = 32'h0008_0000;

endpackage

>>> rtl/handheld_lcd_timing_generator.sv
// Top level of the handheld LCD timing generator: counters, pin-word builder and output register.
//
//   channel | valid       | stall       | payload
//   input   | item_valid  | item_stall  | pixel_byte, swap_request
//   output  | pins_valid  | pins_stall  | pin_word, byte_done, line_number, line_end,
//           |             |             | shown_buffer, swap_done
//
// Each accepted word yields one result word in the next cycle, one per cycle unless stalled.
// The line, word, parity and buffer state advance on the accepting edge. The result is held in
// the output register, built from the old state, but shown_buffer gives the new buffer select.
// The input is stalled only while a held result is itself stalled.
// Reset clears all counters, the parity, the buffer select and the pending swap.
module handheld_lcd_timing_generator (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_stall,
  input  logic [7:0]                 pixel_byte,
  input  logic                       swap_request,
  output logic                       pins_valid,
  input  logic                       pins_stall,
  output logic [31:0]                pin_word,
  output logic                       byte_done,
  output logic [hlcd_pkg::LINE_W-1:0] line_number,
  output logic                       line_end,
  output logic                       shown_buffer,
  output logic                       swap_done
);
  import hlcd_pkg::*;

  logic [LINE_W-1:0] line_count;
  logic [WORD_W-1:0] word_count;
  logic              frame_parity;
  logic              buffer_select;
  logic              swap_pending;

  logic [LINE_W-1:0] line_count_next;
  logic [WORD_W-1:0] word_count_next;
  logic              frame_parity_next;
  logic              buffer_select_next;
  logic              swap_pending_next;

  logic              accept;
  logic              visible;
  logic              pixel_slot;
  logic [WORD_W-1:0] pixel_index;
  logic [1:0]        lo_pair;
  logic [1:0]        hi_pair;
  logic [31:0]       base;
  logic [31:0]       word;
  logic              done;
  logic              last;
  logic              swapped;
  logic [LINE_W:0]   line_inc;

  assign item_stall = pins_valid && pins_stall;
  assign accept     = item_valid && !item_stall;

  assign visible     = line_count < VISIBLE_LAST;
  assign pixel_slot  = visible && (word_count >= FIRST_PIXEL) && (word_count < PIXEL_END);
  assign pixel_index = word_count - FIRST_PIXEL;
  assign last        = word_count >= LAST_WORD;
  assign line_inc    = {1'b0, line_count} + (LINE_W+1)'(1);

  always_comb begin
    lo_pair = pixel_index[0] ? pixel_byte[5:4] : pixel_byte[1:0];
    hi_pair = pixel_index[0] ? pixel_byte[7:6] : pixel_byte[3:2];

    base = '0;
    if (line_count == '0) begin
      base = VSYNC_BITS;
    end
    if (frame_parity ^ line_count[0]) begin
      base = base | FR_BITS;
    end

    word = base;
    done = 1'b0;
    if (pixel_slot) begin
      word = base | CP_BITS | {6'd0, lo_pair, 6'd0, lo_pair, 6'd0, hi_pair, 6'd0, hi_pair};
      done = pixel_index[0];
    end
    if (word_count == LAST_WORD) begin
      word = base | LAST_MARK;
    end
    if (word_count == '0) begin
      word = base | FIRST_MARK;
    end
    if (word_count == WORD_W'(1)) begin
      word = base | SECOND_MARK;
    end
    if ((word_count == CPG_WORD_A) || (word_count == CPG_WORD_B)) begin
      word = word | CPG_BITS;
    end
    if (visible) begin
      if (word_count == HSYNC_WORD) begin
        word = base | HSYNC_MARK;
      end
      if (word_count == FIRST_PIXEL) begin
        word = word | HSYNC_TAIL;
      end
    end
  end

  always_comb begin
    line_count_next    = line_count;
    word_count_next    = word_count + WORD_W'(1);
    frame_parity_next  = frame_parity;
    buffer_select_next = buffer_select;
    swap_pending_next  = swap_pending || swap_request;
    swapped            = 1'b0;
    if (last) begin
      word_count_next = '0;
      if (line_inc >= FRAME_END) begin
        line_count_next = '0;
      end else begin
        line_count_next = line_inc[LINE_W-1:0];
      end
      if ((line_inc < FRAME_END) && (line_inc == BLANK_START)) begin
        frame_parity_next = !frame_parity;
        if (swap_pending_next) begin
          buffer_select_next = !buffer_select;
          swap_pending_next  = 1'b0;
          swapped            = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count    <= '0;
      word_count    <= '0;
      frame_parity  <= 1'b0;
      buffer_select <= 1'b0;
      swap_pending  <= 1'b0;
      pins_valid    <= 1'b0;
    end else begin
      if (accept) begin
        line_count    <= line_count_next;
        word_count    <= word_count_next;
        frame_parity  <= frame_parity_next;
        buffer_select <= buffer_select_next;
        swap_pending  <= swap_pending_next;
        pins_valid    <= 1'b1;
      end else if (!pins_stall) begin
        pins_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pin_word     <= word;
      byte_done    <= done;
      line_number  <= line_count;
      line_end     <= last;
      shown_buffer <= buffer_select_next;
      swap_done    <= swapped;
    end
  end

endmodule
